>>> rtl/core/tscg_pkg.sv
// Shared types and constants for the three-segment color gradient core.
package tscg_pkg;

   // Fraction bits of the Q1.16 ratio; one divider cell per fraction bit.
   localparam int unsigned FRAC_BITS  = 16;
   localparam int unsigned QUOT_BITS  = FRAC_BITS + 1;
   localparam int unsigned RATIO_BITS = QUOT_BITS + 1;
   localparam int unsigned CHAN_BITS  = 8;
   localparam int unsigned DIFF_BITS  = CHAN_BITS + 1;
   localparam int unsigned PROD_BITS  = DIFF_BITS + RATIO_BITS;
   localparam int unsigned COLOR_BITS = 3 * CHAN_BITS;

   localparam logic [QUOT_BITS-1:0] RATIO_ONE = QUOT_BITS'(1) << FRAC_BITS;

   // Gradient stops: purple, blue, teal, red.
   localparam logic [COLOR_BITS-1:0] STOP_COLOR [4] = '{
      24'h800080, 24'h108EC4, 24'h48A39A, 24'hDC143C
   };

   typedef enum logic [1:0] {
      SEG_LOW,
      SEG_MID,
      SEG_HIGH
   } seg_type;

   typedef struct packed {
      logic    valid;
      logic    neg;
      seg_type seg;
   } ctl_type;

endpackage

>>> rtl/core/tscg_div_cell.sv
// One restoring-division cell: yields one quotient bit per transaction and passes it on.
module tscg_div_cell #(
   parameter int unsigned DIV_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tscg_pkg::ctl_type                  up_ctl,
   input  logic [DIV_BITS-1:0]                up_rem,
   input  logic [DIV_BITS-1:0]                up_div,
   input  logic [tscg_pkg::QUOT_BITS-1:0]     up_quot,
   output tscg_pkg::ctl_type                  down_ctl,
   output logic [DIV_BITS-1:0]                down_rem,
   output logic [DIV_BITS-1:0]                down_div,
   output logic [tscg_pkg::QUOT_BITS-1:0]     down_quot
);

   tscg_pkg::ctl_type                 ctl_ff;
   logic [DIV_BITS-1:0]               rem_in, rem_ff;
   logic [DIV_BITS-1:0]               div_ff;
   logic [tscg_pkg::QUOT_BITS-1:0]    quot_in, quot_ff;
   logic [DIV_BITS:0]                 trial;
   logic [DIV_BITS:0]                 diff;
   logic                              fits;

   // rem < div on entry, so both the trial and the difference stay in range
   always_comb begin
      trial   = {up_rem, 1'b0};
      diff    = trial - {1'b0, up_div};
      fits    = (trial >= {1'b0, up_div});
      rem_in  = fits ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
      quot_in = {up_quot[tscg_pkg::QUOT_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      div_ff  <= up_div;
      quot_ff <= quot_in;
   end

   assign down_ctl  = ctl_ff;
   assign down_rem  = rem_ff;
   assign down_div  = div_ff;
   assign down_quot = quot_ff;

endmodule

>>> rtl/core/tscg_blend.sv
// Two-stage interpolation of one color channel by a signed Q1.16 ratio, clamped to 0..255.
module tscg_blend (
   input  logic                                   clock,
   input  logic [tscg_pkg::CHAN_BITS-1:0]         from_chan,
   input  logic [tscg_pkg::CHAN_BITS-1:0]         to_chan,
   input  logic signed [tscg_pkg::RATIO_BITS-1:0] ratio,
   output logic [tscg_pkg::CHAN_BITS-1:0]         chan
);

   localparam int unsigned SHIFT_BITS = tscg_pkg::PROD_BITS - tscg_pkg::FRAC_BITS;
   localparam int unsigned SUM_BITS   = SHIFT_BITS + 1;

   logic signed [tscg_pkg::DIFF_BITS-1:0] diff;
   logic signed [tscg_pkg::PROD_BITS-1:0] prod_in, prod_ff;
   logic [tscg_pkg::CHAN_BITS-1:0]        from_ff;
   logic signed [tscg_pkg::PROD_BITS-1:0] adj;
   logic signed [tscg_pkg::PROD_BITS-1:0] shifted;
   logic signed [SUM_BITS-1:0]            sum;
   logic [tscg_pkg::CHAN_BITS-1:0]        chan_in, chan_ff;

   always_comb begin
      diff    = $signed({1'b0, to_chan}) - $signed({1'b0, from_chan});
      prod_in = tscg_pkg::PROD_BITS'(diff) * tscg_pkg::PROD_BITS'(ratio);
   end

   // truncate toward zero: bias negative products before the arithmetic shift
   always_comb begin
      adj     = prod_ff + (prod_ff[tscg_pkg::PROD_BITS-1]
                           ? tscg_pkg::PROD_BITS'((1 << tscg_pkg::FRAC_BITS) - 1)
                           : tscg_pkg::PROD_BITS'(0));
      shifted = adj >>> tscg_pkg::FRAC_BITS;
      sum     = $signed({{(SUM_BITS - tscg_pkg::CHAN_BITS){1'b0}}, from_ff})
                + $signed(shifted[SUM_BITS-1:0]);
      if (sum[SUM_BITS-1]) begin
         chan_in = '0;
      end else if (sum > $signed(SUM_BITS'((1 << tscg_pkg::CHAN_BITS) - 1))) begin
         chan_in = '1;
      end else begin
         chan_in = sum[tscg_pkg::CHAN_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      from_ff <= from_chan;
      chan_ff <= chan_in;
   end

   assign chan = chan_ff;

endmodule

>>> rtl/core/three_segment_color_gradient_core.sv
// Top level: maps an iteration count to an RGB color along a four-stop gradient.
//
//   channel  ports                              direction  transfer
//   request  start, busy, req_count             in         start && !busy
//   response rsp_valid, rsp_color               out        rsp_valid, one cycle
//   csr      csr_valid, csr_ready, csr_data     in         csr_valid && csr_ready
//
// One request per cycle; busy stays low. The pipeline holds two front stages, one
// restoring-division cell per ratio fraction bit (16), and two blend stages (multiply,
// then round and clamp).
// Synchronous active-high reset clears the pipeline valids and loads count_limit with 100.
// The response side has no back-pressure; csr_ready is always high.
module three_segment_color_gradient_core #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [COUNT_BITS-1:0]               req_count,
   output logic                                rsp_valid,
   output logic [tscg_pkg::COLOR_BITS-1:0]     rsp_color,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [COUNT_BITS-1:0]               csr_data
);

   localparam int unsigned FRAC    = tscg_pkg::FRAC_BITS;
   localparam int unsigned LATENCY = FRAC + 4;
   localparam int unsigned CB      = tscg_pkg::CHAN_BITS;

   logic [COUNT_BITS-1:0]   count_limit_ff;

   // front stage 0
   logic                    s0_valid_ff;
   logic [COUNT_BITS-1:0]   s0_count_in, s0_count_ff;
   logic [COUNT_BITS-1:0]   s0_div_in, s0_div_ff;

   // front stage 1
   logic [COUNT_BITS+1:0]   count3;
   logic [COUNT_BITS:0]     count_inc;
   logic [COUNT_BITS+1:0]   half3;
   logic [COUNT_BITS+1:0]   seg_base;
   logic signed [COUNT_BITS+2:0] num;
   logic [COUNT_BITS+2:0]   mag;
   logic [COUNT_BITS-1:0]   numer;
   logic                    top_bit;
   tscg_pkg::ctl_type       s1_ctl_in, s1_ctl_ff;
   logic [COUNT_BITS-1:0]   s1_rem_in, s1_rem_ff;
   logic [COUNT_BITS-1:0]   s1_div_ff;
   logic [tscg_pkg::QUOT_BITS-1:0] s1_quot_in, s1_quot_ff;

   // divider chain
   tscg_pkg::ctl_type              ctl_chain  [FRAC+1];
   logic [COUNT_BITS-1:0]          rem_chain  [FRAC+1];
   logic [COUNT_BITS-1:0]          div_chain  [FRAC+1];
   logic [tscg_pkg::QUOT_BITS-1:0] quot_chain [FRAC+1];

   // blend
   tscg_pkg::ctl_type                      end_ctl;
   logic signed [tscg_pkg::RATIO_BITS-1:0] ratio;
   logic [1:0]                             from_idx, to_idx;
   logic [tscg_pkg::COLOR_BITS-1:0]        from_color, to_color;
   logic                                   mul_valid_ff;
   logic                                   out_valid_ff;
   logic [CB-1:0]                          red, green, blue;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_limit_ff <= COUNT_BITS'(100);
      end else if (csr_valid && csr_ready) begin
         count_limit_ff <= csr_data;
      end
   end

   // clamp the count; a zero limit divides by one so the ratio comes out zero
   always_comb begin
      s0_count_in = (req_count > count_limit_ff) ? count_limit_ff : req_count;
      s0_div_in   = (count_limit_ff == '0) ? COUNT_BITS'(1) : count_limit_ff;
   end

   // segment: c <= m/3 iff 3c <= m; c <= 2*(m/3) iff 3*ceil(c/2) <= m
   always_comb begin
      count3    = {2'b00, s0_count_ff} + {1'b0, s0_count_ff, 1'b0};
      count_inc = {1'b0, s0_count_ff} + (COUNT_BITS+1)'(1);
      half3     = {2'b00, count_inc[COUNT_BITS:1]} + {1'b0, count_inc[COUNT_BITS:1], 1'b0};
      s1_ctl_in.valid = s0_valid_ff;
      if (count3 <= {2'b00, s0_div_ff}) begin
         s1_ctl_in.seg = tscg_pkg::SEG_LOW;
         seg_base      = '0;
      end else if (half3 <= {2'b00, s0_div_ff}) begin
         s1_ctl_in.seg = tscg_pkg::SEG_MID;
         seg_base      = {2'b00, s0_div_ff};
      end else begin
         s1_ctl_in.seg = tscg_pkg::SEG_HIGH;
         seg_base      = {1'b0, s0_div_ff, 1'b0};
      end
      // num lies in [-1, m]; only the last segment can dip below zero
      num             = $signed({1'b0, count3}) - $signed({1'b0, seg_base});
      s1_ctl_in.neg   = num[COUNT_BITS+2];
      mag             = s1_ctl_in.neg ? (COUNT_BITS+3)'(-num) : (COUNT_BITS+3)'(num);
      numer           = mag[COUNT_BITS-1:0];
      top_bit         = (numer == s0_div_ff);
      s1_rem_in       = top_bit ? '0 : numer;
      s1_quot_in      = {{(tscg_pkg::QUOT_BITS-1){1'b0}}, top_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff       <= 1'b0;
         s1_ctl_ff         <= '0;
         mul_valid_ff      <= 1'b0;
         out_valid_ff      <= 1'b0;
      end else begin
         s0_valid_ff       <= start && !busy;
         s1_ctl_ff         <= s1_ctl_in;
         mul_valid_ff      <= end_ctl.valid;
         out_valid_ff      <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s0_count_ff <= s0_count_in;
      s0_div_ff   <= s0_div_in;
      s1_rem_ff   <= s1_rem_in;
      s1_div_ff   <= s0_div_ff;
      s1_quot_ff  <= s1_quot_in;
   end

   assign ctl_chain[0]  = s1_ctl_ff;
   assign rem_chain[0]  = s1_rem_ff;
   assign div_chain[0]  = s1_div_ff;
   assign quot_chain[0] = s1_quot_ff;

   for (genvar i = 0; i < FRAC; i++) begin : g_cell
      tscg_div_cell #(
         .DIV_BITS (COUNT_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .up_ctl    (ctl_chain[i]),
         .up_rem    (rem_chain[i]),
         .up_div    (div_chain[i]),
         .up_quot   (quot_chain[i]),
         .down_ctl  (ctl_chain[i+1]),
         .down_rem  (rem_chain[i+1]),
         .down_div  (div_chain[i+1]),
         .down_quot (quot_chain[i+1])
      );
   end

   always_comb begin
      end_ctl    = ctl_chain[FRAC];
      ratio      = end_ctl.neg ? -$signed({1'b0, quot_chain[FRAC]})
                               :  $signed({1'b0, quot_chain[FRAC]});
      from_idx   = 2'(end_ctl.seg);
      to_idx     = from_idx + 2'd1;
      from_color = tscg_pkg::STOP_COLOR[from_idx];
      to_color   = tscg_pkg::STOP_COLOR[to_idx];
   end

   tscg_blend u_blend_red (
      .clock     (clock),
      .from_chan (from_color[3*CB-1:2*CB]),
      .to_chan   (to_color[3*CB-1:2*CB]),
      .ratio     (ratio),
      .chan      (red)
   );

   tscg_blend u_blend_green (
      .clock     (clock),
      .from_chan (from_color[2*CB-1:CB]),
      .to_chan   (to_color[2*CB-1:CB]),
      .ratio     (ratio),
      .chan      (green)
   );

   tscg_blend u_blend_blue (
      .clock     (clock),
      .from_chan (from_color[CB-1:0]),
      .to_chan   (to_color[CB-1:0]),
      .ratio     (ratio),
      .chan      (blue)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_color = {red, green, blue};

   // every response traces back to an accepted request
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("response without matching request");

   // the ratio magnitude never exceeds one
   a_ratio_range: assert property (@(posedge clock) disable iff (reset)
      end_ctl.valid |-> (quot_chain[FRAC] <= tscg_pkg::RATIO_ONE))
      else $error("ratio magnitude above one");

   // a negative ratio only comes from the last segment, with a numerator of one
   a_neg_only_high: assert property (@(posedge clock) disable iff (reset)
      (s1_ctl_ff.valid && s1_ctl_ff.neg) |->
         (s1_ctl_ff.seg == tscg_pkg::SEG_HIGH && s1_rem_ff == COUNT_BITS'(1)))
      else $error("unexpected negative numerator");

endmodule

>>> tb/three_segment_color_gradient_core_test.sv
// Self-checking testbench for the four-stop color gradient core.
`timescale 1ns / 1ps

module three_segment_color_gradient_core_test;

   localparam int unsigned COUNT_BITS = 16;
   localparam int unsigned COLOR_BITS = tscg_pkg::COLOR_BITS;
   localparam int unsigned LATENCY    = tscg_pkg::FRAC_BITS + 4;
   localparam int unsigned STALL_MAX  = 5000;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   logic [COUNT_BITS-1:0] req_count = '0;
   logic                  rsp_valid;
   logic [COLOR_BITS-1:0] rsp_color;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [COUNT_BITS-1:0] csr_data  = '0;

   logic [COUNT_BITS-1:0] count_queue [$];
   logic [COLOR_BITS-1:0] color_queue [$];
   logic [COUNT_BITS-1:0] limit_shadow = COUNT_BITS'(100);

   int unsigned counts_taken  = 0;
   int unsigned colors_seen   = 0;
   int unsigned limits_tried  = 1;
   int unsigned mismatches    = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned sender_idle   = 38;
   logic        draining      = 1'b0;

   three_segment_color_gradient_core #(.COUNT_BITS(COUNT_BITS)) DUT (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_count(req_count),
      .rsp_valid(rsp_valid),
      .rsp_color(rsp_color),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   always #10 clock = ~clock;

   // Expected color for one count under a given limit.
   function automatic logic [COLOR_BITS-1:0] gradient_color(
      input logic [COUNT_BITS-1:0] count,
      input logic [COUNT_BITS-1:0] limit
   );
      longint                m, c, third, num, ratio, lo, hi, v;
      tscg_pkg::seg_type     seg;
      logic [COLOR_BITS-1:0] color;
      m = longint'(limit);
      c = longint'(count);
      color = '0;
      if (m == 0) begin
         return tscg_pkg::STOP_COLOR[0];
      end
      if (c > m) begin
         c = m;
      end
      third = m / 3;
      if (c <= third) begin
         seg = tscg_pkg::SEG_LOW;
      end else if (c <= 2 * third) begin
         seg = tscg_pkg::SEG_MID;
      end else begin
         seg = tscg_pkg::SEG_HIGH;
      end
      num   = 3 * c - longint'(seg) * m;
      ratio = (num * 65536) / m;   // may dip below zero in the top segment
      for (int ch = 0; ch < 3; ch++) begin
         lo = longint'((tscg_pkg::STOP_COLOR[int'(seg)] >> (16 - 8 * ch)) & 24'hFF);
         hi = longint'((tscg_pkg::STOP_COLOR[int'(seg) + 1] >> (16 - 8 * ch)) & 24'hFF);
         v  = lo + ((hi - lo) * ratio) / 65536;
         if (v < 0) begin
            v = 0;
         end
         if (v > 255) begin
            v = 255;
         end
         color[16 - 8 * ch +: 8] = v[7:0];
      end
      return color;
   endfunction

   // Random count shaped around the segment edges of the current limit.
   function automatic logic [COUNT_BITS-1:0] pick_count(input logic [COUNT_BITS-1:0] limit);
      int unsigned m, t, mode;
      m    = limit;
      t    = m / 3;
      mode = $urandom_range(9);
      if (mode <= 5) begin
         return COUNT_BITS'($urandom_range(m));
      end else if (mode == 6) begin
         case ($urandom_range(5))
            0: return COUNT_BITS'(t);
            1: return COUNT_BITS'(t + 1);
            2: return COUNT_BITS'(2 * t);
            3: return COUNT_BITS'(2 * t + 1);
            4: return COUNT_BITS'(m);
            default: return COUNT_BITS'((m == 0) ? 0 : m - 1);
         endcase
      end else if (mode == 7 && m < 65535) begin
         return COUNT_BITS'($urandom_range(65535, m + 1));
      end
      return COUNT_BITS'($urandom);
   endfunction

   task automatic wait_idle();
      while (!(count_queue.size() == 0 && !start && color_queue.size() == 0)) begin
         @(negedge clock);
      end
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [COUNT_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      limit_shadow = value;
      csr_valid <= 1'b0;
      limits_tried++;
   endtask

   task automatic queue_phase(input int unsigned n);
      int unsigned m;
      m = limit_shadow;
      // segment edges first, then shaped random counts
      count_queue.push_back('0);
      count_queue.push_back(COUNT_BITS'(m / 3 + 1));
      count_queue.push_back(COUNT_BITS'(2 * (m / 3) + 1));
      count_queue.push_back(COUNT_BITS'(m));
      count_queue.push_back('1);
      for (int i = 0; i < n; i++) begin
         count_queue.push_back(pick_count(limit_shadow));
      end
   endtask

   // Driver: one transaction per accepting edge, predicted when accepted.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            color_queue.push_back(gradient_color(req_count, limit_shadow));
            counts_taken++;
            if (counts_taken % 173 == 90) begin
               draining = 1'b1;
            end
            sender_idle = (counts_taken < 240) ? 38 : (counts_taken < 480) ? 82 : 0;
         end
         if (draining && color_queue.size() == 0) begin
            draining = 1'b0;
         end
         if (start && busy) begin
            // hold the pending transaction
         end else if (count_queue.size() != 0 && !draining &&
                      $urandom_range(99) >= sender_idle) begin
            start     <= 1'b1;
            req_count <= count_queue.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor
   always @(posedge clock) begin
      logic [COLOR_BITS-1:0] want;
      if (!reset && rsp_valid) begin
         colors_seen++;
         if (color_queue.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected color: expected none, actual %06h", $time, rsp_color);
         end else begin
            want = color_queue.pop_front();
            if (rsp_color !== want) begin
               mismatches++;
               $display("%0t: color mismatch: expected %06h, actual %06h",
                        $time, want, rsp_color);
            end
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_MAX) begin
         $display("timeout after %0d quiet cycles at %0t", quiet_cycles, $time);
         $display("three_segment_color_gradient_core regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [COUNT_BITS-1:0] limits [$];
      limits = {16'd0, 16'd65535, 16'd1, 16'd2, 16'd3, 16'd5, 16'd4, 16'd65534,
                16'd299, 16'd1000, 16'd100};
      limits.push_back(COUNT_BITS'($urandom_range(65535)));
      limits.push_back(COUNT_BITS'($urandom_range(40)));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed pass under the reset limit of 100
      count_queue = {16'd0, 16'd1, 16'd33, 16'd34, 16'd35, 16'd66, 16'd67, 16'd68,
                     16'd99, 16'd100, 16'd101, 16'hFFFF, 16'hAAAA, 16'h5555, 16'd50};
      wait_idle();

      foreach (limits[i]) begin
         write_limit(limits[i]);
         queue_phase(45);
         wait_idle();
      end

      $display("checked %0d colors from %0d counts over %0d limit settings",
               colors_seen, counts_taken, limits_tried);
      $display("limits included zero, full scale and remainders giving negative ratios");
      if (mismatches == 0 && color_queue.size() == 0) begin
         $display("three_segment_color_gradient_core regression: pass");
      end else begin
         $display("three_segment_color_gradient_core regression: fail");
      end
      $finish;
   end

endmodule

>>> three_segment_color_gradient_core.f
rtl/core/tscg_pkg.sv
rtl/core/tscg_div_cell.sv
rtl/core/tscg_blend.sv
rtl/core/three_segment_color_gradient_core.sv
tb/three_segment_color_gradient_core_test.sv
